// ===== rtl/gnx_pkg.sv =====
package gnx_pkg;

   localparam int CORD_W       = 6;
   localparam int BOUND_W      = 7;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int NBR_COUNT    = 8;
   localparam int PICK_W       = $clog2(NBR_COUNT);
   localparam int DIAG_FIRST   = 4;
   localparam int WIN_W        = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAG_EN   = 2'd2;

   localparam logic [BOUND_W-1:0] GRID_ROWS_RESET = 7'd64;
   localparam logic [BOUND_W-1:0] GRID_COLS_RESET = 7'd64;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_EXPAND = 1'b1;

   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE  = 2'd0;
   localparam op_type OP_EXPAND = 2'd1;
   localparam op_type OP_MISS   = 2'd2;

   // neighbour order: cardinal first, then diagonal
   localparam logic signed [1:0] NBR_DR [NBR_COUNT] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0,
                                                        2'sd1, -2'sd1, 2'sd1, -2'sd1};
   localparam logic signed [1:0] NBR_DC [NBR_COUNT] = '{2'sd1, 2'sd0, 2'sd0, -2'sd1,
                                                        2'sd1, -2'sd1, -2'sd1, 2'sd1};

   typedef struct packed {
      op_type              op;
      logic [CORD_W-1:0]   row;
      logic [CORD_W-1:0]   col;
      logic                blocked;
   } item_type;

   typedef struct packed {
      logic [BOUND_W-1:0]  rows_lim;
      logic [BOUND_W-1:0]  cols_lim;
      logic                diag_en;
   } cfg_type;

   typedef struct packed {
      logic                clearing;
   } back_status_type;

endpackage

// ===== rtl/gnx_queue.sv =====
module gnx_queue import gnx_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     empty,
   output logic     full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/gnx_front.sv =====
module gnx_front import gnx_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [CORD_W-1:0]     req_row,
   input  logic [CORD_W-1:0]     req_col,
   input  logic                  req_blocked,
   output logic                  push_valid,
   output item_type              push_item,
   input  logic                  queue_full,
   input  back_status_type       back_status,
   output cfg_type               cfg
);

   localparam int BOUND_MAX = (1 << BOUND_W) - 1;
   localparam int ROW_CAP   = (MAX_ROWS > BOUND_MAX) ? BOUND_MAX : MAX_ROWS;
   localparam int COL_CAP   = (MAX_COLS > BOUND_MAX) ? BOUND_MAX : MAX_COLS;

   logic [BOUND_W-1:0]     grid_rows_ff, grid_rows_in;
   logic [BOUND_W-1:0]     grid_cols_ff, grid_cols_in;
   logic                   diag_en_ff, diag_en_in;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   accept;
   logic                   phys_ok;
   logic                   range_ok;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      diag_en_in   = diag_en_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_ROWS: grid_rows_in = pwdata[BOUND_W-1:0];
            CSR_GRID_COLS: grid_cols_in = pwdata[BOUND_W-1:0];
            CSR_DIAG_EN:   diag_en_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_GRID_ROWS: prdata = CSR_DATA_W'(grid_rows_ff);
         CSR_GRID_COLS: prdata = CSR_DATA_W'(grid_cols_ff);
         CSR_DIAG_EN:   prdata = CSR_DATA_W'(diag_en_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_ROWS_RESET;
         grid_cols_ff <= GRID_COLS_RESET;
         diag_en_ff   <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         diag_en_ff   <= diag_en_in;
      end
   end

   // bounds saturated to the physical map
   assign cfg.rows_lim = (grid_rows_ff > BOUND_W'(ROW_CAP)) ? BOUND_W'(ROW_CAP) : grid_rows_ff;
   assign cfg.cols_lim = (grid_cols_ff > BOUND_W'(COL_CAP)) ? BOUND_W'(COL_CAP) : grid_cols_ff;
   assign cfg.diag_en  = diag_en_ff;

   assign busy   = queue_full | back_status.clearing;
   assign accept = start & ~busy;

   assign phys_ok  = (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
   assign range_ok = (BOUND_W'(req_row) < cfg.rows_lim) && (BOUND_W'(req_col) < cfg.cols_lim);

   // writes outside the map are dropped here
   always_comb begin
      push_item.row     = req_row;
      push_item.col     = req_col;
      push_item.blocked = req_blocked;
      if (req_kind == KIND_EXPAND) begin
         push_item.op = range_ok ? OP_EXPAND : OP_MISS;
         push_valid   = accept;
      end else begin
         push_item.op = OP_WRITE;
         push_valid   = accept & phys_ok;
      end
   end

endmodule

// ===== rtl/gnx_back.sv =====
module gnx_back import gnx_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  item_type          head,
   input  logic              empty,
   output logic              pop,
   output back_status_type   status,
   output logic              rsp_valid,
   output logic [CORD_W-1:0] rsp_nbr_row,
   output logic [CORD_W-1:0] rsp_nbr_col,
   output logic              rsp_diagonal_step,
   output logic              rsp_found,
   output logic              rsp_last_of_run
);

   localparam int RA_W = $clog2(MAX_ROWS);
   localparam int CA_W = $clog2(MAX_COLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MASK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [1:0] STEP_LAST = 2'd3;

   logic [MAX_COLS-1:0]             obstacle_mem [MAX_ROWS];
   logic [MAX_COLS-1:0]             rd_word_ff;

   logic [2:0]                      state_ff, state_in;
   logic [RA_W-1:0]                 clr_row_ff, clr_row_in;
   logic [1:0]                      step_ff, step_in;
   logic [CORD_W-1:0]               row_ff, row_in;
   logic [CORD_W-1:0]               col_ff, col_in;
   logic [WIN_W-1:0][WIN_W-1:0]     win_ff, win_in;
   logic [NBR_COUNT-1:0]            mask_ff, mask_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [CORD_W-1:0]               rsp_row_ff, rsp_row_in;
   logic [CORD_W-1:0]               rsp_col_ff, rsp_col_in;
   logic                            rsp_diag_ff, rsp_diag_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            mem_we;
   logic                            mem_clr;
   logic [RA_W-1:0]                 wr_row;
   logic [CA_W-1:0]                 wr_col;
   logic                            wr_bit;
   logic [RA_W-1:0]                 rd_row;

   logic [BOUND_W-1:0]              rd_tgt;
   logic [BOUND_W-1:0]              cap_tgt;
   logic                            cap_row_ok;
   logic [1:0]                      cap_k;
   logic [WIN_W-1:0][BOUND_W-1:0]   col_tgt;
   logic [WIN_W-1:0]                cap_bits;
   logic [NBR_COUNT-1:0]            mask_new;
   logic [PICK_W-1:0]               pick;
   logic [NBR_COUNT-1:0]            rest;

   assign status.clearing = (state_ff == ST_CLEAR);

   // window rows r-1, r, r+1; a wrapped coordinate fails the bound compare
   assign rd_tgt     = BOUND_W'(row_ff) + BOUND_W'(step_ff) - BOUND_W'(1);
   assign rd_row     = RA_W'(rd_tgt);
   assign cap_tgt    = BOUND_W'(row_ff) + BOUND_W'(step_ff) - BOUND_W'(2);
   assign cap_row_ok = cap_tgt < cfg.rows_lim;
   assign cap_k      = step_ff - 2'd1;

   always_comb begin
      for (int j = 0; j < WIN_W; j++) begin
         col_tgt[j]  = BOUND_W'(col_ff) + BOUND_W'(j) - BOUND_W'(1);
         cap_bits[j] = cap_row_ok && (col_tgt[j] < cfg.cols_lim)
                       && !rd_word_ff[CA_W'(col_tgt[j])];
      end
   end

   // no corner cutting: a diagonal needs both adjacent cardinals free
   always_comb begin
      mask_new[0] = win_ff[1][2];
      mask_new[1] = win_ff[2][1];
      mask_new[2] = win_ff[0][1];
      mask_new[3] = win_ff[1][0];
      mask_new[4] = cfg.diag_en & win_ff[2][2] & win_ff[2][1] & win_ff[1][2];
      mask_new[5] = cfg.diag_en & win_ff[0][0] & win_ff[0][1] & win_ff[1][0];
      mask_new[6] = cfg.diag_en & win_ff[2][0] & win_ff[2][1] & win_ff[1][0];
      mask_new[7] = cfg.diag_en & win_ff[0][2] & win_ff[0][1] & win_ff[1][2];
   end

   always_comb begin
      pick = '0;
      for (int i = NBR_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = PICK_W'(i);
         end
      end
   end

   assign rest = mask_ff & ~(NBR_COUNT'(1) << pick);

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      win_in       = win_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_diag_in  = rsp_diag_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_clr      = 1'b0;
      wr_row       = clr_row_ff;
      wr_col       = '0;
      wr_bit       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_clr    = 1'b1;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == RA_W'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                     wr_row = RA_W'(head.row);
                     wr_col = CA_W'(head.col);
                     wr_bit = head.blocked;
                  end
                  OP_EXPAND: begin
                     row_in   = head.row;
                     col_in   = head.col;
                     step_in  = '0;
                     state_in = ST_READ;
                  end
                  OP_MISS: begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = '0;
                     rsp_col_in   = '0;
                     rsp_diag_in  = 1'b0;
                     rsp_found_in = 1'b0;
                     rsp_last_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            step_in = step_ff + 2'd1;
            if (step_ff != 2'd0) begin
               win_in[cap_k] = cap_bits;
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            mask_in  = mask_new;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            if (mask_ff == '0) begin
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_diag_in  = 1'b0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rsp_row_in   = row_ff + CORD_W'(NBR_DR[pick]);
               rsp_col_in   = col_ff + CORD_W'(NBR_DC[pick]);
               rsp_diag_in  = (int'(pick) >= DIAG_FIRST);
               rsp_found_in = 1'b1;
               rsp_last_in  = (rest == '0);
               mask_in      = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      win_ff       <= win_in;
      mask_ff      <= mask_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_diag_ff  <= rsp_diag_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // one map row per word
   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (mem_clr) begin
            obstacle_mem[wr_row] <= '0;
         end else begin
            obstacle_mem[wr_row][wr_col] <= wr_bit;
         end
      end
      rd_word_ff <= obstacle_mem[rd_row];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nbr_row       = rsp_row_ff;
   assign rsp_nbr_col       = rsp_col_ff;
   assign rsp_diagonal_step = rsp_diag_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

// ===== rtl/grid_neighbor_expander.sv =====
// channel   | ports                                        | transaction
// ----------+----------------------------------------------+-----------------------------
// request   | start, busy, req_kind/row/col/blocked        | start high while busy low
// result    | rsp_valid, rsp_nbr_row/col, rsp_diagonal_step,| one cycle on rsp_valid
//           | rsp_found, rsp_last_of_run                   |
// config    | psel, penable, pwrite, paddr, pwdata, prdata | access phase, pready high
//
// a write is done in the back end in the cycle it is popped; an expand goes through pop,
// four read steps that fetch three rows of the obstacle map through its single read
// port, and mask, and then gives its results back to back, one to eight; a query out
// of range gives its single result in the cycle after it is popped
// after reset a clearing pass over all MAX_ROWS map rows holds busy high
// a two-entry queue sits between front and back; busy rises when it is full
// results cannot be held off by the receiver
module grid_neighbor_expander import gnx_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [CORD_W-1:0]     req_row,
   input  logic [CORD_W-1:0]     req_col,
   input  logic                  req_blocked,
   output logic                  rsp_valid,
   output logic [CORD_W-1:0]     rsp_nbr_row,
   output logic [CORD_W-1:0]     rsp_nbr_col,
   output logic                  rsp_diagonal_step,
   output logic                  rsp_found,
   output logic                  rsp_last_of_run
);

   logic            push_valid;
   item_type        push_item;
   item_type        head;
   logic            queue_empty;
   logic            queue_full;
   logic            pop;
   back_status_type back_status;
   cfg_type         cfg;

   gnx_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_blocked (req_blocked),
      .push_valid  (push_valid),
      .push_item   (push_item),
      .queue_full  (queue_full),
      .back_status (back_status),
      .cfg         (cfg)
   );

   gnx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   gnx_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head              (head),
      .empty             (queue_empty),
      .pop               (pop),
      .status            (back_status),
      .rsp_valid         (rsp_valid),
      .rsp_nbr_row       (rsp_nbr_row),
      .rsp_nbr_col       (rsp_nbr_col),
      .rsp_diagonal_step (rsp_diagonal_step),
      .rsp_found         (rsp_found),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== rtl/gnx_checker.sv =====
module gnx_checker import gnx_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic [CORD_W-1:0] rsp_nbr_row,
   input logic [CORD_W-1:0] rsp_nbr_col,
   input logic              rsp_diagonal_step,
   input logic              rsp_found,
   input logic              rsp_last_of_run
);

   // a miss is a lone, zeroed result
   a_miss_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last_of_run && rsp_nbr_row == '0
                                  && rsp_nbr_col == '0 && !rsp_diagonal_step)
      else $error("miss result not zeroed or not last");

   // a run continues without gaps until its last transaction
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_found ##1 (rsp_valid && rsp_found))
      else $error("run broken before last transaction");

   // diagonals come after all cardinals of a run
   a_diag_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_diagonal_step && !rsp_last_of_run |=> rsp_diagonal_step)
      else $error("cardinal neighbour after a diagonal one");

   // map clearing holds off requests right after reset
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("request taken during map clearing");

endmodule

bind grid_neighbor_expander gnx_checker u_gnx_checker (.*);
